[design/fsa_pkg.sv]
`default_nettype none
package fsa_pkg;

    localparam int FREE_ENTRIES_DEF = 64;
    localparam int ADDR_BITS_DEF    = 32;

    typedef enum logic [1:0] {
        OP_FIRST = 2'd0,
        OP_BEST  = 2'd1,
        OP_NEXT  = 2'd2,
        OP_FREE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage
`default_nettype wire

[design/fsa_req_if.sv]
`default_nettype none
interface fsa_req_if import fsa_pkg::*; #(
    parameter int AW = ADDR_BITS_DEF
) ();
    logic          valid;
    logic          ready;
    logic [1:0]    opcode;
    logic [AW-1:0] req_size;
    logic [AW-1:0] seg_start;

    modport source (output valid, opcode, req_size, seg_start, input ready);
    modport sink   (input valid, opcode, req_size, seg_start, output ready);
endinterface
`default_nettype wire

[design/fsa_rsp_if.sv]
`default_nettype none
interface fsa_rsp_if import fsa_pkg::*; #(
    parameter int AW = ADDR_BITS_DEF,
    parameter int CW = $clog2(FREE_ENTRIES_DEF + 1)
) ();
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [AW-1:0] granted_start;
    logic [CW-1:0] free_entries_used;

    modport source (output valid, status, granted_start, free_entries_used, input ready);
    modport sink   (input valid, status, granted_start, free_entries_used, output ready);
endinterface
`default_nettype wire

[design/fsa_seg_ram.sv]
`default_nettype none
module fsa_seg_ram import fsa_pkg::*; #(
    parameter int DEPTH = FREE_ENTRIES_DEF,
    parameter int DW    = 2 * ADDR_BITS_DEF,
    localparam int IW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [IW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/free_segment_allocator_core.sv]
// A request is taken in S_IDLE and scans the stored segments in S_SCAN through the one read
// port of the table memory. It updates the chosen entry in S_ACT and, when the entry at
// place p is removed or one is inserted at place p, shifts the entries behind p down in
// S_SHDN or up in S_SHUP before the result is reported in S_DONE.
// One item is in work at a time; a result waits in S_DONE while the output stalls.
// Synchronous active-low reset empties the table and drops the next-fit pointer.
`default_nettype none
module free_segment_allocator_core import fsa_pkg::*; #(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    fsa_req_if.sink   i_req,
    fsa_rsp_if.source o_rsp
);
    localparam int AW = ADDR_BITS;
    localparam int IW = $clog2(FREE_ENTRIES);
    localparam int CW = $clog2(FREE_ENTRIES + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_ACT  = 6'b000100,
        S_SHDN = 6'b001000,
        S_SHUP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic [1:0]    r_op, n_op;
    logic [AW-1:0] r_req, n_req, r_seg, n_seg;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_nf_idx, n_nf_idx;
    logic          r_nf_valid, n_nf_valid;
    logic [CW-1:0] r_k, n_k;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_pv, n_pv;
    logic [IW-1:0] r_pidx, n_pidx;
    logic          r_found, n_found;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_a_valid, n_a_valid, r_b_valid, n_b_valid;
    logic [AW-1:0] r_a_start, n_a_start, r_a_size, n_a_size;
    logic [AW-1:0] r_b_start, n_b_start, r_b_size, n_b_size;
    logic [AW-1:0] r_best, n_best;
    logic [CW-1:0] r_j, n_j, r_lim, n_lim;
    logic [1:0]    r_res_status, n_res_status;
    logic [AW-1:0] r_res_granted, n_res_granted;
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status, n_out_status;
    logic [AW-1:0] r_out_granted, n_out_granted;
    logic [CW-1:0] r_out_used, n_out_used;

    logic            we;
    logic [IW-1:0]   waddr, raddr;
    logic [2*AW-1:0] wdata, rdata;
    logic [AW-1:0]   rd_start, rd_size, prev_end, free_end;
    logic [CW-1:0]   pos_m1, j_m1, cnt_m1, idx_p1;
    logic            prev_adj, next_adj, stop;

    fsa_seg_ram #(.DEPTH(FREE_ENTRIES), .DW(2 * AW)) u_fsa_seg_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_start = rdata[2*AW-1:AW];
    assign rd_size  = rdata[AW-1:0];
    assign prev_end = r_b_start + r_b_size;
    assign free_end = r_seg + r_req;
    assign prev_adj = r_b_valid && (prev_end == r_seg);
    assign next_adj = r_a_valid && (r_a_start == free_end);
    assign pos_m1   = r_pos - CW'(1);
    assign j_m1     = r_j - CW'(1);
    assign cnt_m1   = r_count - CW'(1);
    assign idx_p1   = CW'(r_idx) + CW'(1);

    assign i_req.ready             = (r_state == S_IDLE);
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_out_status;
    assign o_rsp.granted_start     = r_out_granted;
    assign o_rsp.free_entries_used = r_out_used;

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_req = r_req;       n_seg = r_seg;
        n_count = r_count;   n_nf_idx = r_nf_idx; n_nf_valid = r_nf_valid;
        n_k = r_k;           n_idx = r_idx;     n_pv = r_pv;         n_pidx = r_pidx;
        n_found = r_found;   n_pos = r_pos;     n_a_valid = r_a_valid; n_b_valid = r_b_valid;
        n_a_start = r_a_start; n_a_size = r_a_size;
        n_b_start = r_b_start; n_b_size = r_b_size;
        n_best = r_best;     n_j = r_j;         n_lim = r_lim;
        n_res_status = r_res_status; n_res_granted = r_res_granted;
        n_out_valid = r_out_valid; n_out_status = r_out_status;
        n_out_granted = r_out_granted; n_out_used = r_out_used;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = r_idx;
        stop = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op      = i_req.opcode;
                    n_req     = i_req.req_size;
                    n_seg     = i_req.seg_start;
                    n_k       = '0;
                    n_pv      = 1'b0;
                    n_found   = 1'b0;
                    n_a_valid = 1'b0;
                    n_b_valid = 1'b0;
                    if (i_req.opcode == OP_NEXT && r_nf_valid && CW'(r_nf_idx) < r_count) begin
                        n_idx = r_nf_idx;
                    end else begin
                        n_idx = '0;
                    end
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_pv) begin
                    case (r_op)
                        OP_FREE: begin
                            if (rd_start > r_seg) begin
                                stop      = 1'b1;
                                n_pos     = CW'(r_pidx);
                                n_a_valid = 1'b1;
                                n_a_start = rd_start;
                                n_a_size  = rd_size;
                            end else begin
                                n_b_valid = 1'b1;
                                n_b_start = rd_start;
                                n_b_size  = rd_size;
                            end
                        end
                        OP_BEST: begin
                            if (rd_size >= r_req && (!r_found || (rd_size - r_req) < r_best)) begin
                                n_found   = 1'b1;
                                n_pos     = CW'(r_pidx);
                                n_a_start = rd_start;
                                n_a_size  = rd_size;
                                n_best    = rd_size - r_req;
                            end
                        end
                        default: begin
                            if (rd_size >= r_req) begin
                                stop      = 1'b1;
                                n_found   = 1'b1;
                                n_pos     = CW'(r_pidx);
                                n_a_start = rd_start;
                                n_a_size  = rd_size;
                            end
                        end
                    endcase
                end
                if (stop) begin
                    n_pv    = 1'b0;
                    n_state = S_ACT;
                end else if (r_k < r_count) begin
                    raddr  = r_idx;
                    n_k    = r_k + CW'(1);
                    n_idx  = (idx_p1 == r_count) ? '0 : idx_p1[IW-1:0];
                    n_pv   = 1'b1;
                    n_pidx = r_idx;
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        if (r_op == OP_FREE) begin
                            n_pos = r_count;
                        end
                        n_state = S_ACT;
                    end
                end
            end
            S_ACT: begin
                n_lim         = r_count;
                n_pv          = 1'b0;
                n_res_status  = ST_DONE;
                n_res_granted = '0;
                n_state       = S_DONE;
                if (r_op == OP_FREE) begin
                    if (prev_adj && next_adj) begin
                        we    = 1'b1;
                        waddr = pos_m1[IW-1:0];
                        wdata = {r_b_start, r_b_size + r_req + r_a_size};
                    end else if (prev_adj) begin
                        we    = 1'b1;
                        waddr = pos_m1[IW-1:0];
                        wdata = {r_b_start, r_b_size + r_req};
                    end else if (next_adj) begin
                        we    = 1'b1;
                        waddr = r_pos[IW-1:0];
                        wdata = {r_seg, r_a_size + r_req};
                    end else if (r_count >= CW'(FREE_ENTRIES)) begin
                        n_res_status = ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                        if (r_nf_valid && CW'(r_nf_idx) >= r_pos) begin
                            n_nf_idx = r_nf_idx + IW'(1);
                        end
                        n_j     = r_count;
                        n_state = S_SHUP;
                    end
                end else if (!r_found) begin
                    n_res_status = ST_NOFIT;
                end else begin
                    n_res_granted = r_a_start;
                    if (r_a_size != r_req) begin
                        we    = 1'b1;
                        waddr = r_pos[IW-1:0];
                        wdata = {r_a_start + r_req, r_a_size - r_req};
                        if (r_op == OP_NEXT) begin
                            n_nf_idx   = r_pos[IW-1:0];
                            n_nf_valid = 1'b1;
                        end
                    end
                end
                if ((r_op == OP_FREE && prev_adj && next_adj) ||
                    (r_op != OP_FREE && r_found && r_a_size == r_req)) begin
                    n_count = cnt_m1;
                    n_j     = r_pos + CW'(1);
                    n_state = S_SHDN;
                    if (r_op == OP_NEXT) begin
                        n_nf_idx   = r_pos[IW-1:0];
                        n_nf_valid = (r_pos < cnt_m1);
                    end else if (r_nf_valid) begin
                        if (CW'(r_nf_idx) > r_pos) begin
                            n_nf_idx = r_nf_idx - IW'(1);
                        end else if (CW'(r_nf_idx) == r_pos && r_pos >= cnt_m1) begin
                            n_nf_valid = 1'b0;
                        end
                    end
                end
            end
            S_SHDN: begin
                if (r_pv) begin
                    we    = 1'b1;
                    waddr = r_pidx - IW'(1);
                    wdata = rdata;
                end
                if (r_j < r_lim) begin
                    raddr  = r_j[IW-1:0];
                    n_j    = r_j + CW'(1);
                    n_pv   = 1'b1;
                    n_pidx = r_j[IW-1:0];
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHUP: begin
                if (r_pv) begin
                    we    = 1'b1;
                    waddr = r_pidx + IW'(1);
                    wdata = rdata;
                end
                if (r_j > r_pos) begin
                    raddr  = j_m1[IW-1:0];
                    n_j    = j_m1;
                    n_pv   = 1'b1;
                    n_pidx = j_m1[IW-1:0];
                end else begin
                    n_pv = 1'b0;
                    if (!r_pv) begin
                        we      = 1'b1;
                        waddr   = r_pos[IW-1:0];
                        wdata   = {r_seg, r_req};
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_res_status;
                    n_out_granted = r_res_granted;
                    n_out_used    = r_count;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_nf_idx    <= '0;
            r_nf_valid  <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_nf_idx    <= n_nf_idx;
            r_nf_valid  <= n_nf_valid;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;           r_req <= n_req;         r_seg <= n_seg;
        r_k <= n_k;             r_idx <= n_idx;         r_pidx <= n_pidx;
        r_found <= n_found;     r_pos <= n_pos;
        r_a_valid <= n_a_valid; r_b_valid <= n_b_valid;
        r_a_start <= n_a_start; r_a_size <= n_a_size;
        r_b_start <= n_b_start; r_b_size <= n_b_size;
        r_best <= n_best;       r_j <= n_j;             r_lim <= n_lim;
        r_res_status <= n_res_status;
        r_res_granted <= n_res_granted;
        r_out_status <= n_out_status;
        r_out_granted <= n_out_granted;
        r_out_used <= n_out_used;
    end
endmodule
`default_nettype wire

[design/fsa_checker.sv]
`default_nettype none
module fsa_checker import fsa_pkg::*; #(
    parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
    parameter int AW = ADDR_BITS_DEF,
    parameter int CW = $clog2(FREE_ENTRIES_DEF + 1)
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_req_valid,
    input wire logic          i_req_ready,
    input wire logic          i_rsp_valid,
    input wire logic          i_rsp_ready,
    input wire logic [1:0]    i_status,
    input wire logic [AW-1:0] i_granted,
    input wire logic [CW-1:0] i_used
);
    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_used <= CW'(FREE_ENTRIES))
        else $error("table count exceeds capacity");

    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status != ST_DONE |-> i_granted == '0)
        else $error("start address reported without a grant");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == ST_FULL |-> i_used == CW'(FREE_ENTRIES))
        else $error("table full reported while entries remain");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second item taken while one is in work");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result item dropped before it was taken");
endmodule

bind free_segment_allocator_core fsa_checker #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .AW           (ADDR_BITS),
    .CW           (CW)
) u_fsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_granted   (o_rsp.granted_start),
    .i_used      (o_rsp.free_entries_used)
);
`default_nettype wire
